// ===== hdl/trlc_pkg.sv =====
// Shared types and constants for the timed relay lock controller.
package trlc_pkg;

   localparam int unsigned CMD_W     = 3;
   localparam int unsigned ID_W      = 4;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned MASK_W    = 4;
   localparam int unsigned ELAPSED_W = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_DURATION      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENFORCE_PERMISSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_MASK       = 2'd2;

   localparam logic [ELAPSED_W-1:0] OPEN_DURATION_RESET = 16'd5000;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK         = 3'd0,
      CMD_OPEN         = 3'd1,
      CMD_OPEN_CHECKED = 3'd2,
      CMD_CLOSE_ONE    = 3'd3,
      CMD_CLOSE_ALL    = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OPENED    = 3'd0,
      ST_REFRESHED = 3'd1,
      ST_INVALID   = 3'd2,
      ST_DENIED    = 3'd3,
      ST_OTHER     = 3'd4
   } status_type;

   // per-lock update strobes, already qualified by the processing step
   typedef struct packed {
      logic tick;
      logic open_set;
      logic close_set;
   } lock_ctl_type;

endpackage

// ===== hdl/trlc_if.sv =====
// Request and response channel interfaces of the relay lock controller.
interface trlc_req_if import trlc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ID_W-1:0]   lock_id;

   modport source (output valid, output command, output lock_id, input ready);
   modport sink (input valid, input command, input lock_id, output ready);
endinterface

interface trlc_rsp_if import trlc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                accepted;
   logic [STATUS_W-1:0] status;
   logic [MASK_W-1:0]   open_mask;
   logic                any_open;
   logic [MASK_W-1:0]   auto_closed;

   modport source (output valid, output accepted, output status, output open_mask,
                   output any_open, output auto_closed, input ready);
   modport sink (input valid, input accepted, input status, input open_mask,
                 input any_open, input auto_closed, output ready);
endinterface

// ===== hdl/trlc_lock_cell.sv =====
// One relay lock: open flag and saturating elapsed tick counter.
module trlc_lock_cell
   import trlc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  lock_ctl_type         ctl,
   input  logic [ELAPSED_W-1:0] open_duration,
   output logic                 open_now,
   output logic                 open_next,
   output logic                 timeout
);

   logic                 open_ff, open_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [ELAPSED_W-1:0] elapsed_inc;

   always_comb begin
      elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
      open_in     = open_ff;
      elapsed_in  = elapsed_ff;
      timeout     = 1'b0;
      if (ctl.tick && open_ff) begin
         if (elapsed_inc >= open_duration) begin
            // reached the window: drop the relay
            open_in    = 1'b0;
            elapsed_in = '0;
            timeout    = 1'b1;
         end else begin
            elapsed_in = elapsed_inc;
         end
      end else if (ctl.open_set) begin
         open_in    = 1'b1;
         elapsed_in = '0;
      end else if (ctl.close_set) begin
         open_in    = 1'b0;
         elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         elapsed_ff <= '0;
      end else begin
         open_ff    <= open_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign open_now  = open_ff;
   assign open_next = open_in;

endmodule

// ===== hdl/timed_relay_lock_controller_core.sv =====
// Top level of the timed relay lock controller.
// A request accepted on the request channel is held in the input register and then
// in the result register, which drives the response channel; the per-lock timers
// update in a single pass. Throughput: one request per cycle unless responses stall.
// Reset: synchronous, active high; all locks closed, timers zero, open_duration 5000,
// enforcement off, allowed mask clear, both channel registers empty.
module timed_relay_lock_controller_core
   import trlc_pkg::*;
#(
   parameter int unsigned LOCKS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   trlc_req_if.sink             req_chan,
   trlc_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int unsigned PAD_W = (LOCKS < MASK_W) ? MASK_W : LOCKS;

   // configuration
   logic [ELAPSED_W-1:0] open_duration_ff;
   logic                 enforce_ff;
   logic [MASK_W-1:0]    allowed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_duration_ff <= OPEN_DURATION_RESET;
         enforce_ff       <= 1'b0;
         allowed_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPEN_DURATION:      open_duration_ff <= csr_wdata[ELAPSED_W-1:0];
            CSR_ENFORCE_PERMISSION: enforce_ff       <= csr_wdata[0];
            CSR_ALLOWED_MASK:       allowed_ff       <= csr_wdata[MASK_W-1:0];
            default:                ;
         endcase
      end
   end

   // input register
   logic             in_valid_ff;
   logic [CMD_W-1:0] in_cmd_ff;
   logic [ID_W-1:0]  in_id_ff;
   logic             out_valid_ff;
   logic             advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_cmd_ff <= req_chan.command;
         in_id_ff  <= req_chan.lock_id;
      end
   end

   // command decode
   logic             is_tick, is_open, is_close_one, is_close_all, is_checked;
   logic             id_valid, permitted, granted, was_open;
   logic [LOCKS-1:0] id_sel;
   logic [LOCKS-1:0] open_now, open_next, timeout;
   lock_ctl_type     lock_ctl [LOCKS];
   status_type       status_in;

   always_comb begin
      is_tick      = 1'b0;
      is_open      = 1'b0;
      is_close_one = 1'b0;
      is_close_all = 1'b0;
      is_checked   = 1'b0;
      case (cmd_type'(in_cmd_ff))
         CMD_TICK:         is_tick = 1'b1;
         CMD_OPEN:         is_open = 1'b1;
         CMD_OPEN_CHECKED: begin
            is_open    = 1'b1;
            is_checked = 1'b1;
         end
         CMD_CLOSE_ONE:    is_close_one = 1'b1;
         CMD_CLOSE_ALL:    is_close_all = 1'b1;
         default:          ;
      endcase
   end

   always_comb begin
      for (int i = 0; i < LOCKS; i++) begin
         id_sel[i] = (in_id_ff == ID_W'(i));
      end
   end

   assign id_valid  = {1'b0, in_id_ff} < (ID_W+1)'(LOCKS);
   // locks beyond the mask width carry no allowed bit
   assign permitted = (in_id_ff < ID_W'(MASK_W)) && allowed_ff[in_id_ff[1:0]];
   assign granted   = id_valid && !((is_checked || enforce_ff) && !permitted);
   assign was_open  = |(open_now & id_sel);

   always_comb begin
      if (!is_open)          status_in = ST_OTHER;
      else if (!id_valid)    status_in = ST_INVALID;
      else if (!granted)     status_in = ST_DENIED;
      else if (was_open)     status_in = ST_REFRESHED;
      else                   status_in = ST_OPENED;
   end

   for (genvar g = 0; g < LOCKS; g++) begin : g_lock
      assign lock_ctl[g].tick      = advance && is_tick;
      assign lock_ctl[g].open_set  = advance && is_open && granted && id_sel[g];
      assign lock_ctl[g].close_set = advance &&
                                     (is_close_all || (is_close_one && id_sel[g]));

      trlc_lock_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (lock_ctl[g]),
         .open_duration (open_duration_ff),
         .open_now      (open_now[g]),
         .open_next     (open_next[g]),
         .timeout       (timeout[g])
      );
   end

   // result register
   logic [PAD_W-1:0]    open_pad, timeout_pad;
   logic                accepted_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [MASK_W-1:0]   open_mask_ff, auto_closed_ff;
   logic                any_open_ff;

   assign open_pad    = PAD_W'(open_next);
   assign timeout_pad = PAD_W'(timeout);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accepted_ff    <= is_open && granted;
         status_ff      <= status_in;
         open_mask_ff   <= open_pad[MASK_W-1:0];
         any_open_ff    <= |open_next;
         auto_closed_ff <= timeout_pad[MASK_W-1:0];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.accepted    = accepted_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.open_mask   = open_mask_ff;
   assign rsp_chan.any_open    = any_open_ff;
   assign rsp_chan.auto_closed = auto_closed_ff;

endmodule

// ===== verif/tb_timed_relay_lock_controller_core.sv =====
// Self-checking testbench for the timed relay lock controller core.
module tb_timed_relay_lock_controller_core;
   import trlc_pkg::*;

   localparam int unsigned NUM_LOCKS   = 4;
   localparam int unsigned IDLE_PCT    = 6;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASE_REQS  = 190;
   localparam int unsigned NUM_PHASES  = 8;

   typedef struct packed {
      logic                accepted;
      logic [STATUS_W-1:0] status;
      logic [MASK_W-1:0]   open_mask;
      logic                any_open;
      logic [MASK_W-1:0]   auto_closed;
   } lock_result_type;

   class relay_state_tracker;
      logic [ELAPSED_W-1:0] duration;
      logic                 enforce;
      logic [MASK_W-1:0]    allowed;
      logic [NUM_LOCKS-1:0] open_bits;
      logic [ELAPSED_W-1:0] elapsed_cnt [NUM_LOCKS];
      lock_result_type      pending_responses [$];
      int unsigned          mismatches;

      function new();
         duration   = OPEN_DURATION_RESET;
         enforce    = 1'b0;
         allowed    = '0;
         open_bits  = '0;
         mismatches = 0;
         foreach (elapsed_cnt[i]) elapsed_cnt[i] = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_OPEN_DURATION:      duration = data[ELAPSED_W-1:0];
            CSR_ENFORCE_PERMISSION: enforce  = data[0];
            CSR_ALLOWED_MASK:       allowed  = data[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      function void close_lock(int unsigned n);
         open_bits[n]   = 1'b0;
         elapsed_cnt[n] = '0;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
         lock_result_type res;
         logic            permit;
         res        = '0;
         res.status = ST_OTHER;
         case (cmd)
            CMD_TICK: begin
               for (int unsigned n = 0; n < NUM_LOCKS; n++) begin
                  if (open_bits[n]) begin
                     if (elapsed_cnt[n] != ELAPSED_MAX) elapsed_cnt[n]++;
                     if (elapsed_cnt[n] >= duration) begin
                        close_lock(n);
                        if (n < MASK_W) res.auto_closed[n] = 1'b1;
                     end
                  end
               end
            end
            CMD_OPEN, CMD_OPEN_CHECKED: begin
               permit = (id < MASK_W) ? allowed[id] : 1'b0;
               if (id >= NUM_LOCKS) begin
                  res.status = ST_INVALID;
               end else if ((cmd == CMD_OPEN_CHECKED || enforce) && !permit) begin
                  res.status = ST_DENIED;
               end else begin
                  elapsed_cnt[id] = '0;
                  res.accepted    = 1'b1;
                  if (open_bits[id]) begin
                     res.status = ST_REFRESHED;
                  end else begin
                     open_bits[id] = 1'b1;
                     res.status    = ST_OPENED;
                  end
               end
            end
            CMD_CLOSE_ONE: if (id < NUM_LOCKS) close_lock(id);
            CMD_CLOSE_ALL: for (int unsigned n = 0; n < NUM_LOCKS; n++) close_lock(n);
            default: ;
         endcase
         for (int unsigned n = 0; n < NUM_LOCKS && n < MASK_W; n++)
            res.open_mask[n] = open_bits[n];
         res.any_open = |open_bits;
         pending_responses.push_back(res);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(lock_result_type got);
         lock_result_type want;
         if (pending_responses.size() == 0) begin
            $display("%0t: response with none outstanding, expected none, actual %0h",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_responses.pop_front();
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("status", want.status, got.status);
         compare_field("open_mask", want.open_mask, got.open_mask);
         compare_field("any_open", want.any_open, got.any_open);
         compare_field("auto_closed", want.auto_closed, got.auto_closed);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   logic no_idle;
   logic hold_request;
   int unsigned hold_left;
   lock_result_type seen;

   relay_state_tracker tracker = new();

   trlc_req_if req_chan ();
   trlc_rsp_if rsp_chan ();

   timed_relay_lock_controller_core #(.LOCKS(NUM_LOCKS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            tracker.note_request(req_chan.command, req_chan.lock_id);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.accepted    = rsp_chan.accepted;
            seen.status      = rsp_chan.status;
            seen.open_mask   = rsp_chan.open_mask;
            seen.any_open    = rsp_chan.any_open;
            seen.auto_closed = rsp_chan.auto_closed;
            tracker.check_response(seen);
         end
      end
   end

   // response side: random back-pressure, plus a long hold-off on request
   initial begin
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("tb_timed_relay_lock_controller_core: FAIL");
      $finish;
   end

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
      int unsigned gap;
      gap = (!no_idle && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.lock_id <= id;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // drop valid and hold until every response has been seen
   task automatic drain_responses();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      tracker.set_register(idx, data);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_window(input logic [CSR_DAT_W-1:0] dur, input logic en,
                             input logic [MASK_W-1:0] mask);
      write_register(CSR_OPEN_DURATION, dur);
      write_register(CSR_ENFORCE_PERMISSION, {{(CSR_DAT_W-1){1'b0}}, en});
      write_register(CSR_ALLOWED_MASK, {{(CSR_DAT_W-MASK_W){1'b0}}, mask});
   endtask

   task automatic send_random_request();
      int unsigned r;
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0] id;
      r = $urandom_range(99);
      if (r < 38)      cmd = CMD_TICK;
      else if (r < 58) cmd = CMD_OPEN;
      else if (r < 73) cmd = CMD_OPEN_CHECKED;
      else if (r < 87) cmd = CMD_CLOSE_ONE;
      else if (r < 93) cmd = CMD_CLOSE_ALL;
      else             cmd = CMD_W'($urandom_range(5, 7));
      id = ($urandom_range(99) < 85) ? ID_W'($urandom_range(NUM_LOCKS - 1))
                                     : ID_W'($urandom_range(15));
      send_request(cmd, id);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      no_idle          = 1'b0;
      hold_request     = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.command = '0;
      req_chan.lock_id = '0;
      rsp_chan.ready   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: long duration, no enforcement, empty mask
      send_request(CMD_OPEN, 4'd0);
      send_request(CMD_OPEN, 4'd0);
      send_request(CMD_OPEN, 4'd15);
      send_request(CMD_OPEN, 4'd4);
      send_request(CMD_OPEN_CHECKED, 4'd1);
      send_request(CMD_OPEN_CHECKED, 4'd12);
      send_request(CMD_CLOSE_ONE, 4'd9);
      send_request(3'd5, 4'd3);
      send_request(3'd6, 4'd0);
      send_request(3'd7, 4'd15);
      send_request(CMD_TICK, 4'd0);
      send_request(CMD_CLOSE_ONE, 4'd0);
      send_request(CMD_OPEN, 4'd1);
      send_request(CMD_OPEN, 4'd2);
      send_request(CMD_OPEN, 4'd3);
      send_request(CMD_CLOSE_ALL, 4'd0);
      drain_responses();

      // zero duration closes on the very next tick
      set_window(16'd0, 1'b1, 4'b0101);
      send_request(CMD_OPEN, 4'd1);
      send_request(CMD_OPEN, 4'd2);
      send_request(CMD_OPEN_CHECKED, 4'd0);
      send_request(CMD_TICK, 4'd0);
      send_request(CMD_TICK, 4'd0);
      drain_responses();

      set_window(16'd1, 1'b0, 4'b1111);
      send_request(CMD_OPEN, 4'd3);
      send_request(CMD_TICK, 4'd0);
      drain_responses();

      // hold locks open through a full window
      set_window(16'd64, 1'b0, 4'b0000);
      send_request(CMD_OPEN, 4'd3);
      send_request(CMD_OPEN, 4'd0);
      repeat (64) send_request(CMD_TICK, 4'd0);
      send_request(CMD_TICK, 4'd0);
      drain_responses();

      for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
         no_idle = 1'b0;
         case (phase)
            0: set_window(CSR_DAT_W'($urandom_range(2, 8)), 1'b0, MASK_W'($urandom_range(15)));
            1: set_window(16'd0, 1'b1, 4'b1111);
            2: set_window(16'hFFFF, 1'b1, 4'b0000);
            3: set_window(CSR_DAT_W'($urandom_range(1, 20)), 1'b1,
                          MASK_W'($urandom_range(15)));
            4: set_window(16'd1, 1'b0, 4'b1010);
            5: set_window(CSR_DAT_W'($urandom_range(3, 40)), 1'($urandom_range(1)),
                          MASK_W'($urandom_range(15)));
            6: set_window(16'd2, 1'b1, 4'b1111);
            default: set_window(CSR_DAT_W'($urandom_range(5, 15)), 1'b0, 4'b0000);
         endcase
         if (phase == 4) no_idle = 1'b1;
         for (int unsigned k = 0; k < PHASE_REQS; k++) begin
            if (phase == 3 && k == 50) hold_request = 1'b1;
            send_random_request();
         end
         drain_responses();
      end

      no_idle = 1'b0;
      drain_responses();
      if (tracker.mismatches == 0 && tracker.pending_responses.size() == 0) begin
         $display("tb_timed_relay_lock_controller_core: PASS");
      end else begin
         $display("tb_timed_relay_lock_controller_core: FAIL");
      end
      $finish;
   end

endmodule

// ===== timed_relay_lock_controller_core.f =====
hdl/trlc_pkg.sv
hdl/trlc_if.sv
hdl/trlc_lock_cell.sv
hdl/timed_relay_lock_controller_core.sv
verif/tb_timed_relay_lock_controller_core.sv
